>>> hw/rtl/hcp_nbr_pkg.sv
// Shared types, constants and the neighbor offset table of the HCP neighbor index block.
package hcp_nbr_pkg;

  localparam int IDX_W      = 30;
  localparam int DIR_W      = 4;
  localparam int CFG_W      = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int NEIGHBOURS = 12;
  localparam int GROUPS     = 4;

  localparam logic [CFG_W-1:0] DIM_RESET = 11'd64;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROWS    = 2'd0,
    CFG_COLUMNS = 2'd1,
    CFG_LAYERS  = 2'd2
  } cfg_reg_t;

  typedef logic signed [1:0] coef_t;

  localparam coef_t STEP_M1 = -2'sd1;
  localparam coef_t STEP_Z0 = 2'sd0;
  localparam coef_t STEP_P1 = 2'sd1;

  // coefficients of 1, rows and rows*columns
  typedef struct packed {
    coef_t one;
    coef_t row;
    coef_t plane;
  } step_t;

  // group index is {odd_layer, odd_column}
  localparam step_t STEP_TABLE [GROUPS][NEIGHBOURS] = '{
    // even layer, even column
    '{'{STEP_M1, STEP_Z0, STEP_Z0}, '{STEP_P1, STEP_Z0, STEP_Z0},
      '{STEP_M1, STEP_M1, STEP_Z0}, '{STEP_Z0, STEP_M1, STEP_Z0},
      '{STEP_M1, STEP_P1, STEP_Z0}, '{STEP_Z0, STEP_P1, STEP_Z0},
      '{STEP_Z0, STEP_M1, STEP_M1}, '{STEP_M1, STEP_Z0, STEP_M1},
      '{STEP_Z0, STEP_Z0, STEP_M1}, '{STEP_Z0, STEP_M1, STEP_P1},
      '{STEP_M1, STEP_Z0, STEP_P1}, '{STEP_Z0, STEP_Z0, STEP_P1}},
    // even layer, odd column
    '{'{STEP_M1, STEP_Z0, STEP_Z0}, '{STEP_P1, STEP_Z0, STEP_Z0},
      '{STEP_Z0, STEP_M1, STEP_Z0}, '{STEP_P1, STEP_M1, STEP_Z0},
      '{STEP_Z0, STEP_P1, STEP_Z0}, '{STEP_P1, STEP_P1, STEP_Z0},
      '{STEP_Z0, STEP_M1, STEP_M1}, '{STEP_Z0, STEP_Z0, STEP_M1},
      '{STEP_P1, STEP_Z0, STEP_M1}, '{STEP_Z0, STEP_M1, STEP_P1},
      '{STEP_Z0, STEP_Z0, STEP_P1}, '{STEP_P1, STEP_Z0, STEP_P1}},
    // odd layer, even column
    '{'{STEP_M1, STEP_Z0, STEP_Z0}, '{STEP_P1, STEP_Z0, STEP_Z0},
      '{STEP_Z0, STEP_M1, STEP_Z0}, '{STEP_P1, STEP_M1, STEP_Z0},
      '{STEP_Z0, STEP_P1, STEP_Z0}, '{STEP_P1, STEP_P1, STEP_Z0},
      '{STEP_Z0, STEP_Z0, STEP_M1}, '{STEP_P1, STEP_Z0, STEP_M1},
      '{STEP_Z0, STEP_P1, STEP_M1}, '{STEP_Z0, STEP_Z0, STEP_P1},
      '{STEP_P1, STEP_Z0, STEP_P1}, '{STEP_Z0, STEP_P1, STEP_P1}},
    // odd layer, odd column
    '{'{STEP_M1, STEP_Z0, STEP_Z0}, '{STEP_P1, STEP_Z0, STEP_Z0},
      '{STEP_M1, STEP_M1, STEP_Z0}, '{STEP_Z0, STEP_M1, STEP_Z0},
      '{STEP_M1, STEP_P1, STEP_Z0}, '{STEP_Z0, STEP_P1, STEP_Z0},
      '{STEP_M1, STEP_Z0, STEP_M1}, '{STEP_Z0, STEP_Z0, STEP_M1},
      '{STEP_Z0, STEP_P1, STEP_M1}, '{STEP_M1, STEP_Z0, STEP_P1},
      '{STEP_Z0, STEP_Z0, STEP_P1}, '{STEP_Z0, STEP_P1, STEP_P1}}
  };

  // word moving down the divider pipeline
  typedef struct packed {
    logic [IDX_W-1:0] src;
    logic [DIR_W-1:0] dir;
    logic             in_range;
    logic [IDX_W-1:0] rem;
    logic             lay_odd;
    logic             col_odd;
  } item_t;

endpackage

>>> hw/rtl/hcp_nbr_in_if.sv
// Input channel interface: source voxel index and direction.
interface hcp_nbr_in_if;
  logic                           valid;
  logic                           ready;
  logic [hcp_nbr_pkg::IDX_W-1:0]  voxel_index;
  logic [hcp_nbr_pkg::DIR_W-1:0]  direction;

  modport source (output valid, output voxel_index, output direction, input ready);
  modport sink   (input valid, input voxel_index, input direction, output ready);
endinterface

>>> hw/rtl/hcp_nbr_out_if.sv
// Result channel interface: neighbor index and out-of-range flag.
interface hcp_nbr_out_if;
  logic                           valid;
  logic                           ready;
  logic [hcp_nbr_pkg::IDX_W-1:0]  target_index;
  logic                           out_of_range;

  modport source (output valid, output target_index, output out_of_range, input ready);
  modport sink   (input valid, input target_index, input out_of_range, output ready);
endinterface

>>> hw/rtl/hcp_nbr_cfg_if.sv
// Configuration write channel interface: register index and write data.
interface hcp_nbr_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [hcp_nbr_pkg::CFG_IDX_W-1:0]  index;
  logic [hcp_nbr_pkg::CFG_W-1:0]      data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> hw/rtl/hcp_nbr_cfg.sv
// Lattice dimension registers and the registered derived sizes (plane and voxel count).
module hcp_nbr_cfg #(
  parameter int DIM_BITS = 10
) (
  input  logic                   clk,
  input  logic                   rst_n,
  hcp_nbr_cfg_if.sink            cfg_ch,
  output logic [DIM_BITS:0]      r_eff,
  output logic [2*DIM_BITS:0]    cr,
  output logic [3*DIM_BITS:0]    vox,
  output logic                   busy
);

  localparam int DW  = DIM_BITS + 1;
  localparam int CRW = 2*DIM_BITS + 1;
  localparam int VW  = 3*DIM_BITS + 1;
  localparam int EW  = (DW > hcp_nbr_pkg::CFG_W) ? DW : hcp_nbr_pkg::CFG_W;
  localparam logic [EW-1:0] TOP = EW'(1) << DIM_BITS;
  // derived values go through three register levels
  localparam logic [1:0] SETTLE = 2'd3;

  logic [hcp_nbr_pkg::CFG_W-1:0] rows_r, columns_r, layers_r;
  logic [DW-1:0]  r_eff_r, c_eff_r, l_eff_r;
  logic [CRW-1:0] cr_r;
  logic [VW-1:0]  vox_r;
  logic [1:0]     settle_r, settle_nxt;

  function automatic logic [DW-1:0] eff_dim(logic [hcp_nbr_pkg::CFG_W-1:0] v);
    logic [EW-1:0] x;
    x = EW'(v);
    if (x == '0) x = EW'(1);
    if (x > TOP) x = TOP;
    return DW'(x);
  endfunction

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r    <= hcp_nbr_pkg::DIM_RESET;
      columns_r <= hcp_nbr_pkg::DIM_RESET;
      layers_r  <= hcp_nbr_pkg::DIM_RESET;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      unique case (cfg_ch.index)
        hcp_nbr_pkg::CFG_ROWS:    rows_r    <= cfg_ch.data;
        hcp_nbr_pkg::CFG_COLUMNS: columns_r <= cfg_ch.data;
        hcp_nbr_pkg::CFG_LAYERS:  layers_r  <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  always_comb begin
    settle_nxt = settle_r;
    if (cfg_ch.valid && cfg_ch.ready) settle_nxt = SETTLE;
    else if (settle_r != '0)          settle_nxt = settle_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) settle_r <= SETTLE;
    else        settle_r <= settle_nxt;
  end

  always_ff @(posedge clk) begin
    r_eff_r <= eff_dim(rows_r);
    c_eff_r <= eff_dim(columns_r);
    l_eff_r <= eff_dim(layers_r);
    cr_r    <= CRW'(r_eff_r) * CRW'(c_eff_r);
    vox_r   <= VW'(cr_r) * VW'(l_eff_r);
  end

  assign r_eff = r_eff_r;
  assign cr    = cr_r;
  assign vox   = vox_r;
  assign busy  = (settle_r != '0);

endmodule

>>> hw/rtl/hcp_nbr_div_stage.sv
// One restoring-division step: conditional subtract of a shifted divisor, one quotient bit.
module hcp_nbr_div_stage #(
  parameter int PW    = 31,
  parameter int DVW   = 21,
  parameter int SHIFT = 0,
  parameter bit LAYER = 1'b1
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_valid,
  input  hcp_nbr_pkg::item_t  in_item,
  input  logic [DVW-1:0]      divisor,
  output logic                out_valid,
  output hcp_nbr_pkg::item_t  out_item
);

  logic [PW-1:0]       rem_ext, sub;
  logic                take;
  hcp_nbr_pkg::item_t  item_nxt, item_r;
  logic                valid_r;

  always_comb begin
    rem_ext  = PW'(in_item.rem);
    sub      = PW'(divisor) << SHIFT;
    take     = (rem_ext >= sub);
    item_nxt = in_item;
    if (take) item_nxt.rem = hcp_nbr_pkg::IDX_W'(rem_ext - sub);
    // only the quotient LSB matters: it is the parity
    if (SHIFT == 0) begin
      if (LAYER) item_nxt.lay_odd = take;
      else       item_nxt.col_odd = take;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n)  valid_r <= 1'b0;
    else if (en) valid_r <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (en) item_r <= item_nxt;
  end

  assign out_valid = valid_r;
  assign out_item  = item_r;

endmodule

>>> hw/rtl/hcp_nbr_offset.sv
// Offset table lookup, neighbor sum and range check; its last stage is the output register.
module hcp_nbr_offset #(
  parameter int DW  = 11,
  parameter int CRW = 21,
  parameter int VW  = 31,
  parameter int SW  = 33
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            en,
  input  logic                            in_valid,
  input  hcp_nbr_pkg::item_t              in_item,
  input  logic [DW-1:0]                   r_eff,
  input  logic [CRW-1:0]                  cr,
  input  logic [VW-1:0]                   vox,
  output logic                            out_valid,
  output logic [hcp_nbr_pkg::IDX_W-1:0]   out_target,
  output logic                            out_oor
);

  hcp_nbr_pkg::step_t              coef;
  logic [1:0]                      grp;
  logic [hcp_nbr_pkg::DIR_W-1:0]   didx;
  logic signed [SW-1:0]            r_s, cr_s, row_term, plane_term, val_nxt, vox_s;

  logic                            a_valid_r, a_ok_r;
  logic signed [SW-1:0]            a_val_r;
  logic [hcp_nbr_pkg::IDX_W-1:0]   a_src_r;

  logic                            ok;
  logic                            out_valid_r, out_oor_r;
  logic [hcp_nbr_pkg::IDX_W-1:0]   out_target_r, target_nxt;

  // stage A: neighbor sum
  always_comb begin
    grp  = {in_item.lay_odd, in_item.col_odd};
    didx = in_item.in_range ? in_item.dir : '0;
    coef = hcp_nbr_pkg::STEP_TABLE[grp][didx];
    r_s  = SW'($signed({1'b0, r_eff}));
    cr_s = SW'($signed({1'b0, cr}));
    unique case (coef.row)
      hcp_nbr_pkg::STEP_M1: row_term = -r_s;
      hcp_nbr_pkg::STEP_P1: row_term = r_s;
      default:              row_term = '0;
    endcase
    unique case (coef.plane)
      hcp_nbr_pkg::STEP_M1: plane_term = -cr_s;
      hcp_nbr_pkg::STEP_P1: plane_term = cr_s;
      default:              plane_term = '0;
    endcase
    val_nxt = SW'($signed({1'b0, in_item.src})) + SW'(coef.one) + row_term + plane_term;
  end

  always_ff @(posedge clk) begin
    if (!rst_n)  a_valid_r <= 1'b0;
    else if (en) a_valid_r <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_val_r <= val_nxt;
      a_src_r <= in_item.src;
      a_ok_r  <= in_item.in_range;
    end
  end

  // stage B: range check and select
  always_comb begin
    vox_s      = SW'($signed({1'b0, vox}));
    ok         = a_ok_r && !a_val_r[SW-1] && (a_val_r < vox_s);
    target_nxt = ok ? a_val_r[hcp_nbr_pkg::IDX_W-1:0] : a_src_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n)  out_valid_r <= 1'b0;
    else if (en) out_valid_r <= a_valid_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_target_r <= target_nxt;
      out_oor_r    <= !ok;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_target = out_target_r;
  assign out_oor    = out_oor_r;

endmodule

>>> hw/rtl/hcp_lattice_neighbor_index_top.sv
// Top level: HCP lattice neighbor index pipeline (parity dividers, offset sum, range check).
// Word path: input register, layer and column divider stages, sum register, output register.
// Throughput: one word per cycle; the two restoring dividers take one quotient bit per stage.
// The whole pipeline advances together and holds while the output word waits.
// Reset and every config write hold in_ch.ready low while plane and voxel
// counts are recomputed; after reset all dimensions are 64.
module hcp_lattice_neighbor_index_top #(
  parameter int DIM_BITS = 10
) (
  input  logic           clk,
  input  logic           rst_n,
  hcp_nbr_in_if.sink     in_ch,
  hcp_nbr_out_if.source  out_ch,
  hcp_nbr_cfg_if.sink    cfg_ch
);

  localparam int DW     = DIM_BITS + 1;
  localparam int CRW    = 2*DIM_BITS + 1;
  localparam int VW     = 3*DIM_BITS + 1;
  localparam int PW     = ((VW > hcp_nbr_pkg::IDX_W) ? VW : hcp_nbr_pkg::IDX_W) + 1;
  localparam int SW     = PW + 2;
  localparam int NSTAGE = 2*DIM_BITS;

  logic [DW-1:0]  r_eff;
  logic [CRW-1:0] cr;
  logic [VW-1:0]  vox;
  logic           cfg_busy;
  logic           adv, in_accept;

  logic                s0_valid_r;
  hcp_nbr_pkg::item_t  s0_item_r, s0_item_nxt;

  logic                stg_valid [0:NSTAGE];
  hcp_nbr_pkg::item_t  stg_item  [0:NSTAGE];

  hcp_nbr_cfg #(.DIM_BITS(DIM_BITS)) u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .r_eff  (r_eff),
    .cr     (cr),
    .vox    (vox),
    .busy   (cfg_busy)
  );

  assign adv          = !out_ch.valid || out_ch.ready;
  assign in_ch.ready  = adv && !cfg_busy;
  assign in_accept    = in_ch.valid && in_ch.ready;

  always_comb begin
    s0_item_nxt.src      = in_ch.voxel_index;
    s0_item_nxt.dir      = in_ch.direction;
    s0_item_nxt.in_range = (in_ch.direction < hcp_nbr_pkg::DIR_W'(hcp_nbr_pkg::NEIGHBOURS))
                           && (PW'(in_ch.voxel_index) < PW'(vox));
    s0_item_nxt.rem      = in_ch.voxel_index;
    s0_item_nxt.lay_odd  = 1'b0;
    s0_item_nxt.col_odd  = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n)   s0_valid_r <= 1'b0;
    else if (adv) s0_valid_r <= in_accept;
  end

  always_ff @(posedge clk) begin
    if (adv) s0_item_r <= s0_item_nxt;
  end

  assign stg_valid[0] = s0_valid_r;
  assign stg_item[0]  = s0_item_r;

  // layer = index / (rows*columns), then column = remainder / rows
  for (genvar k = 0; k < DIM_BITS; k++) begin : g_layer
    hcp_nbr_div_stage #(
      .PW(PW), .DVW(CRW), .SHIFT(DIM_BITS-1-k), .LAYER(1'b1)
    ) u_stage (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (adv),
      .in_valid  (stg_valid[k]),
      .in_item   (stg_item[k]),
      .divisor   (cr),
      .out_valid (stg_valid[k+1]),
      .out_item  (stg_item[k+1])
    );
  end

  for (genvar j = 0; j < DIM_BITS; j++) begin : g_column
    hcp_nbr_div_stage #(
      .PW(PW), .DVW(DW), .SHIFT(DIM_BITS-1-j), .LAYER(1'b0)
    ) u_stage (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (adv),
      .in_valid  (stg_valid[DIM_BITS+j]),
      .in_item   (stg_item[DIM_BITS+j]),
      .divisor   (r_eff),
      .out_valid (stg_valid[DIM_BITS+j+1]),
      .out_item  (stg_item[DIM_BITS+j+1])
    );
  end

  hcp_nbr_offset #(.DW(DW), .CRW(CRW), .VW(VW), .SW(SW)) u_offset (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (adv),
    .in_valid   (stg_valid[NSTAGE]),
    .in_item    (stg_item[NSTAGE]),
    .r_eff      (r_eff),
    .cr         (cr),
    .vox        (vox),
    .out_valid  (out_ch.valid),
    .out_target (out_ch.target_index),
    .out_oor    (out_ch.out_of_range)
  );

  // a config write blocks new words until derived sizes settle
  a_cfg_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_ch.valid && cfg_ch.ready) |=> !in_ch.ready)
    else $error("input accepted right after a config write");

  // a waiting result freezes the whole pipeline, input included
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.ready) |-> !in_ch.ready)
    else $error("input ready while output word is stalled");

  // a stalled pipeline keeps its first stage
  a_stall_holds_s0: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(s0_valid_r))
    else $error("first stage changed during a stall");

endmodule

>>> verif/tb.sv
`timescale 1ns / 1ps
// Testbench for the HCP lattice neighbor index block: directed and random lookups, scoreboarded.
module tb;
  import hcp_nbr_pkg::*;

  localparam int PIPE_LAT = 2 * 10 + 3;
  localparam int DIM_LIMIT = 1024;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RANDOM_PHASES = 6;
  localparam int WORDS_PER_PHASE = 120;

  // coefficients of 1, rows, rows*columns; entry = dir + 24*odd_layer + 12*odd_column
  localparam int HOP [48][3] = '{
    '{-1, 0, 0}, '{1, 0, 0}, '{-1, -1, 0}, '{0, -1, 0}, '{-1, 1, 0}, '{0, 1, 0},
    '{0, -1, -1}, '{-1, 0, -1}, '{0, 0, -1}, '{0, -1, 1}, '{-1, 0, 1}, '{0, 0, 1},
    '{-1, 0, 0}, '{1, 0, 0}, '{0, -1, 0}, '{1, -1, 0}, '{0, 1, 0}, '{1, 1, 0},
    '{0, -1, -1}, '{0, 0, -1}, '{1, 0, -1}, '{0, -1, 1}, '{0, 0, 1}, '{1, 0, 1},
    '{-1, 0, 0}, '{1, 0, 0}, '{0, -1, 0}, '{1, -1, 0}, '{0, 1, 0}, '{1, 1, 0},
    '{0, 0, -1}, '{1, 0, -1}, '{0, 1, -1}, '{0, 0, 1}, '{1, 0, 1}, '{0, 1, 1},
    '{-1, 0, 0}, '{1, 0, 0}, '{-1, -1, 0}, '{0, -1, 0}, '{-1, 1, 0}, '{0, 1, 0},
    '{-1, 0, -1}, '{0, 0, -1}, '{0, 1, -1}, '{-1, 0, 1}, '{0, 0, 1}, '{0, 1, 1}
  };

  typedef struct packed {
    logic [IDX_W-1:0] target;
    logic             flagged;
  } nbr_result_t;

  logic clk = 1'b0;
  logic rst_n;

  hcp_nbr_in_if  in_ch();
  hcp_nbr_out_if out_ch();
  hcp_nbr_cfg_if cfg_ch();

  hcp_lattice_neighbor_index_top u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  logic [CFG_W-1:0] rows_reg = DIM_RESET;
  logic [CFG_W-1:0] cols_reg = DIM_RESET;
  logic [CFG_W-1:0] lays_reg = DIM_RESET;

  nbr_result_t pending_nbrs[$];
  int          miss_count = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          stall_cycles = 0;
  int          quiet_cycles = 0;

  function automatic longint dim_used(input logic [CFG_W-1:0] v);
    if (v == 0) return 1;
    if (v > DIM_LIMIT) return DIM_LIMIT;
    return longint'(v);
  endfunction

  function automatic longint lattice_voxels();
    return dim_used(rows_reg) * dim_used(cols_reg) * dim_used(lays_reg);
  endfunction

  function automatic nbr_result_t predict_neighbor(input logic [IDX_W-1:0] src,
                                                   input logic [DIR_W-1:0] dir);
    nbr_result_t res;
    longint      s;
    longint      r;
    longint      plane;
    longint      vox;
    longint      hop_to;
    int          grp;
    s = src;
    r = dim_used(rows_reg);
    plane = r * dim_used(cols_reg);
    vox = plane * dim_used(lays_reg);
    res.target = src;
    res.flagged = 1'b1;
    if (dir < NEIGHBOURS && s < vox) begin
      grp = int'(dir) + 24 * int'((s / plane) % 2) + 12 * int'(((s % plane) / r) % 2);
      hop_to = s + HOP[grp][0] + HOP[grp][1] * r + HOP[grp][2] * plane;
      if (hop_to >= 0 && hop_to < vox) begin
        res.target = hop_to[IDX_W-1:0];
        res.flagged = 1'b0;
      end
    end
    return res;
  endfunction

  // mostly in-lattice sources, with boundary hits, sources past the end and raw noise
  function automatic logic [IDX_W-1:0] random_source();
    longint vox;
    longint r;
    longint plane;
    longint base;
    vox = lattice_voxels();
    r = dim_used(rows_reg);
    plane = r * dim_used(cols_reg);
    case ($urandom_range(99) / 5)
      0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12, 13: base = $urandom_range(vox - 1, 0);
      14, 15, 16: begin
        case ($urandom_range(3))
          0: base = 0;
          1: base = vox - 1;
          2: base = plane * $urandom_range(vox / plane - 1, 0);
          default: base = r * $urandom_range(vox / r - 1, 0);
        endcase
        base = base + int'($urandom_range(4)) - 2;
      end
      17, 18: base = vox + $urandom_range(15);
      default: base = $urandom;
    endcase
    return base[IDX_W-1:0];
  endfunction

  function automatic logic [DIR_W-1:0] random_direction();
    if ($urandom_range(9) == 0) return DIR_W'(NEIGHBOURS + $urandom_range(3));
    return DIR_W'($urandom_range(NEIGHBOURS - 1));
  endfunction

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.voxel_index = '0;
    in_ch.direction = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = CFG_ROWS;
    cfg_ch.data = '0;
  end

  // receiver: random stalls, plus a long hold-off while stall_cycles runs down
  always @(posedge clk) begin
    out_ch.ready <= (stall_cycles == 0) && ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (stall_cycles != 0) stall_cycles <= stall_cycles - 1;
  end

  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready)
      pending_nbrs.push_back(predict_neighbor(in_ch.voxel_index, in_ch.direction));
  end

  task automatic note_miss(input string what, input nbr_result_t want, input nbr_result_t got);
    if (miss_count < 10)
      $display("%s: expected target %0d flag %0d, got target %0d flag %0d",
               what, want.target, want.flagged, got.target, got.flagged);
    miss_count++;
  endtask

  always @(posedge clk) begin : check_results
    nbr_result_t want;
    nbr_result_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.target = out_ch.target_index;
      got.flagged = out_ch.out_of_range;
      if (pending_nbrs.size() == 0) begin
        note_miss("unexpected word", '0, got);
      end else begin
        want = pending_nbrs.pop_front();
        if (got.target !== want.target || got.flagged !== want.flagged)
          note_miss("mismatch", want, got);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_word(input logic [IDX_W-1:0] src, input logic [DIR_W-1:0] dir);
    if ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_ch.valid <= 1'b1;
    in_ch.voxel_index <= src;
    in_ch.direction <= dir;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic send_random(input int count);
    for (int i = 0; i < count; i++) send_word(random_source(), random_direction());
  endtask

  // let the last word's accepting edge pass so its prediction is queued before we look
  task automatic wait_drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_nbrs.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t which, input logic [CFG_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= which;
    cfg_ch.data <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    case (which)
      CFG_ROWS:    rows_reg = value;
      CFG_COLUMNS: cols_reg = value;
      CFG_LAYERS:  lays_reg = value;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_lattice(input logic [CFG_W-1:0] r, input logic [CFG_W-1:0] c,
                             input logic [CFG_W-1:0] l);
    wait_drain();
    write_reg(CFG_ROWS, r);
    write_reg(CFG_COLUMNS, c);
    write_reg(CFG_LAYERS, l);
  endtask

  task automatic set_idling(input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct <= recv_pct;
  endtask

  // 64^3 after reset: all twelve hops from the origin, the far corner, each parity
  // group, directions past eleven and sources beyond the lattice
  task automatic test_reset_lattice();
    for (int d = 0; d < NEIGHBOURS; d++) send_word('0, DIR_W'(d));
    send_word(30'd262143, 4'd1);
    send_word(30'd262143, 4'd5);
    send_word(30'd262143, 4'd11);
    send_word(30'd4160, 4'd6);
    send_word(30'd64, 4'd3);
    send_word(30'd4096, 4'd8);
    send_word(30'd100, 4'd12);
    send_word(30'd100, 4'd15);
    send_word(30'd262144, 4'd0);
    send_word(30'h3FFFFFFF, 4'd11);
  endtask

  // zero rows reads as one, oversize columns and layers clamp to 1024
  task automatic test_dim_clamp();
    set_lattice(11'd0, 11'd2047, 11'd1025);
    send_word(30'd0, 4'd9);
    send_word(30'd1048575, 4'd11);
    send_word(30'd1024, 4'd7);
  endtask

  task automatic test_random_lattices();
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph)
        0: set_lattice(11'd2, 11'd2, 11'd2);
        1: set_lattice(11'd1024, 11'd1024, 11'd1024);
        2: set_lattice(11'd3, 11'd5, 11'd7);
        3: set_lattice(11'd1, 11'd0, 11'd2047);
        4: set_lattice(CFG_W'($urandom_range(1024, 2)), CFG_W'($urandom_range(1024, 2)),
                       CFG_W'($urandom_range(1024, 2)));
        default: set_lattice(CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom));
      endcase
      if (ph < 2) set_idling(7, 57);
      else if (ph < 4) set_idling(57, 7);
      else set_idling(0, 0);
      send_random(WORDS_PER_PHASE);
    end
  endtask

  // output held off long enough for the pipeline to fill and back up the input
  task automatic test_backpressure();
    set_lattice(11'd64, 11'd64, 11'd64);
    set_idling(0, 0);
    stall_cycles <= 400;
    send_random(80);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    set_idling(7, 57);
    test_reset_lattice();
    test_dim_clamp();
    test_random_lattices();
    test_backpressure();
    wait_drain();
    repeat (PIPE_LAT + 10) @(posedge clk);
    if (pending_nbrs.size() != 0) miss_count++;
    if (miss_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
